// ===== src/rof_pkg.sv =====
// ----------------------------------------------------------------------------
// rof_pkg
// Shared constants, types and helpers for the radius outlier filter.
// ----------------------------------------------------------------------------
package rof_pkg;

   // store geometry
   localparam int MAX_POINTS     = 1024;
   localparam int ADDR_BITS      = $clog2(MAX_POINTS);
   localparam int COUNT_BITS     = ADDR_BITS + 1;
   localparam int COORD_BITS     = 24;
   localparam int INDEX_BITS     = 10;

   // register widths
   localparam int RADIUS_BITS    = 16;
   localparam int RATIO_BITS     = 12;
   localparam int PTS_BITS       = 8;
   localparam int FACTOR_BITS    = 4;
   localparam int PHASE_BITS     = 4;

   // threshold arithmetic: dividend is 4 * (ratio * 1024)^2 = ratio^2 << 22
   localparam int RATIO_SHIFT    = 22;
   localparam int TSQ_BITS       = 2 * RATIO_BITS;
   localparam int DVD_BITS       = TSQ_BITS + RATIO_SHIFT;
   localparam int SQ_BITS        = 2 * COORD_BITS + 1;
   localparam int REM_BITS       = SQ_BITS + 1;
   localparam int ROOT_BITS      = 18;
   localparam int ROOT_STEPS     = ROOT_BITS / 2;
   localparam int SAT_LIMIT      = 511 * 511;
   localparam int N_BITS         = PTS_BITS + 1;
   localparam int N_SAT          = 256;
   localparam int STEP_BITS      = 6;
   localparam int R2_BITS        = 2 * RADIUS_BITS;

   // job queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = QPTR_BITS + 1;

   // configuration port
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;

   // commands
   localparam logic [1:0] CMD_CLEAR      = 2'd0;
   localparam logic [1:0] CMD_LOAD_QUERY = 2'd1;
   localparam logic [1:0] CMD_LOAD_REF   = 2'd2;
   localparam logic [1:0] CMD_CLASSIFY   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_SEARCH_RADIUS = 3'd0;
   localparam logic [2:0] REG_DISTANCE_RATIO = 3'd1;
   localparam logic [2:0] REG_MIN_POINTS    = 3'd2;
   localparam logic [2:0] REG_MAX_POINTS    = 3'd3;
   localparam logic [2:0] REG_DOWNSAMPLE    = 3'd4;
   localparam logic [2:0] REG_POSE_X        = 3'd5;
   localparam logic [2:0] REG_POSE_Y        = 3'd6;

   // job kinds
   localparam logic JOB_WRITE    = 1'b0;
   localparam logic JOB_CLASSIFY = 1'b1;

   typedef struct packed {
      logic [RADIUS_BITS-1:0]       radius;
      logic [RATIO_BITS-1:0]        distance_ratio;
      logic [PTS_BITS-1:0]          need_lo;
      logic [PTS_BITS-1:0]          need_hi;
      logic [FACTOR_BITS-1:0]       thin_factor;
      logic signed [COORD_BITS-1:0] pose_x;
      logic signed [COORD_BITS-1:0] pose_y;
   } cfg_type;

   typedef struct packed {
      logic                         kind;
      logic                         invalid;
      logic [ADDR_BITS-1:0]         addr;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COUNT_BITS-1:0]        count;
   } job_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]        result_index;
      logic signed [COORD_BITS-1:0] result_x;
      logic signed [COORD_BITS-1:0] result_y;
      logic [PTS_BITS-1:0]          neighbor_count;
      logic [PTS_BITS-1:0]          required_count;
      logic                         is_inlier;
      logic                         index_invalid;
   } result_type;

   // absolute difference of two coordinates
   function automatic logic [COORD_BITS-1:0] coord_mag(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] d;
      begin
         d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
         if (d[COORD_BITS]) begin
            coord_mag = COORD_BITS'(-d);
         end else begin
            coord_mag = d[COORD_BITS-1:0];
         end
      end
   endfunction

   // a factor of zero acts as one
   function automatic logic [FACTOR_BITS-1:0] eff_factor(
      input logic [FACTOR_BITS-1:0] f);
      begin
         eff_factor = (f == '0) ? FACTOR_BITS'(1) : f;
      end
   endfunction

endpackage

// ===== src/rof_ram.sv =====
// ----------------------------------------------------------------------------
// rof_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rof_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/rof_front.sv =====
// ----------------------------------------------------------------------------
// rof_front
// Accepts input words, thins reference points, tracks the fill count and
// turns kept load words into store writes and classify words into jobs.
// ----------------------------------------------------------------------------
module rof_front (
   input  logic                               clock,
   input  logic                               reset,
   input  rof_pkg::cfg_type                   cfg,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [1:0]                         req_command,
   input  logic signed [rof_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [rof_pkg::COORD_BITS-1:0] req_point_y,
   input  logic [rof_pkg::INDEX_BITS-1:0]     req_point_index,
   output logic                               q_push,
   output rof_pkg::job_type                   q_job,
   input  logic                               q_full
);

   logic [rof_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [rof_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic                           accept;
   logic                           has_room;
   logic                           do_push;
   logic [rof_pkg::PHASE_BITS:0]   phase_inc;
   logic [rof_pkg::FACTOR_BITS-1:0] factor;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign has_room  = count_ff < rof_pkg::COUNT_BITS'(rof_pkg::MAX_POINTS);
   assign factor    = rof_pkg::eff_factor(cfg.thin_factor);
   assign phase_inc = {1'b0, phase_ff} + 1'b1;

   // command decode
   always_comb begin
      count_in     = count_ff;
      phase_in     = phase_ff;
      do_push      = 1'b0;
      q_job.kind   = rof_pkg::JOB_WRITE;
      q_job.invalid = 1'b0;
      q_job.addr   = count_ff[rof_pkg::ADDR_BITS-1:0];
      q_job.x      = req_point_x;
      q_job.y      = req_point_y;
      q_job.count  = count_ff;
      unique case (req_command)
         rof_pkg::CMD_CLEAR: begin
            count_in = '0;
            phase_in = '0;
         end
         rof_pkg::CMD_LOAD_QUERY: begin
            if (has_room) begin
               do_push  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         rof_pkg::CMD_LOAD_REF: begin
            if (phase_ff == '0 && has_room) begin
               do_push  = 1'b1;
               count_in = count_ff + 1'b1;
            end
            if (phase_inc >= {1'b0, factor}) begin
               phase_in = '0;
            end else begin
               phase_in = phase_inc[rof_pkg::PHASE_BITS-1:0];
            end
         end
         rof_pkg::CMD_CLASSIFY: begin
            do_push       = 1'b1;
            q_job.kind    = rof_pkg::JOB_CLASSIFY;
            q_job.addr    = rof_pkg::ADDR_BITS'(req_point_index);
            q_job.invalid = {1'b0, req_point_index} >= count_ff;
         end
         default: begin
         end
      endcase
   end

   assign q_push = accept && do_push;

   // fill count and thinning phase
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== src/rof_queue.sv =====
// ----------------------------------------------------------------------------
// rof_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module rof_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rof_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output rof_pkg::job_type head_job,
   output logic             empty
);

   rof_pkg::job_type              job_ff [rof_pkg::QUEUE_DEPTH];
   logic [rof_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rof_pkg::QCNT_BITS-1:0] cnt_ff;
   logic                          do_push, do_pop;

   assign full     = cnt_ff == rof_pkg::QCNT_BITS'(rof_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_job = job_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/rof_back.sv =====
// ----------------------------------------------------------------------------
// rof_back
// Executes jobs: store writes, and classification through a serial divider,
// a serial square root, a serial count divider and a pipelined store scan.
// ----------------------------------------------------------------------------
module rof_back (
   input  logic                clock,
   input  logic                reset,
   input  rof_pkg::cfg_type    cfg,
   input  logic                q_empty,
   input  rof_pkg::job_type    q_job,
   output logic                q_pop,
   output logic                ram_we,
   output logic [rof_pkg::ADDR_BITS-1:0]    ram_waddr,
   output logic [2*rof_pkg::COORD_BITS-1:0] ram_wdata,
   output logic [rof_pkg::ADDR_BITS-1:0]    ram_raddr,
   input  logic [2*rof_pkg::COORD_BITS-1:0] ram_rdata,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rof_pkg::result_type rsp_word
);

   localparam int CB = rof_pkg::COORD_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FETCH = 4'd1;
   localparam logic [3:0] ST_MULT  = 4'd2;
   localparam logic [3:0] ST_SUM   = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_RINIT = 4'd5;
   localparam logic [3:0] ST_ROOT  = 4'd6;
   localparam logic [3:0] ST_CLAMP = 4'd7;
   localparam logic [3:0] ST_QDIV  = 4'd8;
   localparam logic [3:0] ST_SCAN  = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // control state
   logic [3:0]                        state_ff, state_in;
   logic [rof_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                              out_valid_ff, out_valid_in;
   logic [rof_pkg::COUNT_BITS-1:0]    issue_ff, issue_in;
   logic                              v1_ff, v1_in, v2_ff, v3_ff;

   // datapath registers
   rof_pkg::result_type               out_ff, out_in;
   logic                              inv_ff, inv_in;
   logic [rof_pkg::ADDR_BITS-1:0]     idx_ff, idx_in;
   logic [rof_pkg::COUNT_BITS-1:0]    snap_ff, snap_in;
   logic signed [CB-1:0]              cx_ff, cx_in, cy_ff, cy_in;
   logic [CB-1:0]                     ax_ff, ax_in, ay_ff, ay_in;
   logic [2*CB-1:0]                   sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [rof_pkg::TSQ_BITS-1:0]      tsq_ff, tsq_in;
   logic [rof_pkg::R2_BITS-1:0]       r2_ff, r2_in;
   logic [rof_pkg::SQ_BITS-1:0]       s_ff, s_in;
   logic [rof_pkg::DVD_BITS-1:0]      dvd_ff, dvd_in;
   logic [rof_pkg::SQ_BITS-1:0]       rem_ff, rem_in;
   logic [rof_pkg::ROOT_BITS-1:0]     rv_ff, rv_in, rr_ff, rr_in, rbit_ff, rbit_in;
   logic [rof_pkg::N_BITS-1:0]        n_ff, n_in;
   logic [rof_pkg::PTS_BITS-1:0]      qd_ff, qd_in;
   logic [rof_pkg::FACTOR_BITS-1:0]   qrem_ff, qrem_in;
   logic [rof_pkg::PTS_BITS-1:0]      req_ff, req_in;
   logic [rof_pkg::PTS_BITS-1:0]      cnt_ff, cnt_in;
   logic [rof_pkg::RADIUS_BITS-1:0]   dx_ff, dy_ff;
   logic                              near2_ff, near3_ff;
   logic [rof_pkg::R2_BITS-1:0]       px_ff, py_ff;

   // combinational helpers
   logic [rof_pkg::REM_BITS-1:0]      rem_sh;
   logic [rof_pkg::ROOT_BITS-1:0]     root_sum, rr_next;
   logic [rof_pkg::N_BITS-1:0]        clamp_lo, clamp_c;
   logic [rof_pkg::FACTOR_BITS:0]     qrem_sh;
   logic [rof_pkg::FACTOR_BITS-1:0]   factor;
   logic [CB-1:0]                     sdx, sdy;
   logic                              snear;
   logic [rof_pkg::R2_BITS:0]         dist2;

   assign factor    = rof_pkg::eff_factor(cfg.thin_factor);
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;
   assign ram_waddr = q_job.addr;
   assign ram_wdata = {q_job.x, q_job.y};

   // scan stage one: distance to the centre point
   assign sdx   = rof_pkg::coord_mag(ram_rdata[2*CB-1:CB], cx_ff);
   assign sdy   = rof_pkg::coord_mag(ram_rdata[CB-1:0], cy_ff);
   assign snear = (sdx <= CB'(cfg.radius)) && (sdy <= CB'(cfg.radius));
   assign dist2 = {1'b0, px_ff} + {1'b0, py_ff};

   // serial steps of divider and root
   assign rem_sh   = {rem_ff, dvd_ff[rof_pkg::DVD_BITS-1]};
   assign root_sum = rr_ff + rbit_ff;
   assign rr_next  = (rv_ff >= root_sum) ? ((rr_ff >> 1) + rbit_ff) : (rr_ff >> 1);
   assign qrem_sh  = {qrem_ff, qd_ff[rof_pkg::PTS_BITS-1]};
   assign clamp_lo = (n_ff > {1'b0, cfg.need_lo}) ? n_ff : {1'b0, cfg.need_lo};
   assign clamp_c  = (clamp_lo > {1'b0, cfg.need_hi}) ? {1'b0, cfg.need_hi}
                                                       : clamp_lo;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      issue_in     = issue_ff;
      v1_in        = 1'b0;
      inv_in       = inv_ff;
      idx_in       = idx_ff;
      snap_in      = snap_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      tsq_in       = tsq_ff;
      r2_in        = r2_ff;
      s_in         = s_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      rv_in        = rv_ff;
      rr_in        = rr_ff;
      rbit_in      = rbit_ff;
      n_in         = n_ff;
      qd_in        = qd_ff;
      qrem_in      = qrem_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = issue_ff[rof_pkg::ADDR_BITS-1:0];

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = q_job.addr;
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_job.kind == rof_pkg::JOB_WRITE) begin
                  ram_we = 1'b1;
               end else begin
                  idx_in  = q_job.addr;
                  snap_in = q_job.count;
                  inv_in  = q_job.invalid;
                  state_in = q_job.invalid ? ST_DONE : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cx_in    = ram_rdata[2*CB-1:CB];
            cy_in    = ram_rdata[CB-1:0];
            ax_in    = rof_pkg::coord_mag(ram_rdata[2*CB-1:CB], cfg.pose_x);
            ay_in    = rof_pkg::coord_mag(ram_rdata[CB-1:0], cfg.pose_y);
            state_in = ST_MULT;
         end
         ST_MULT: begin
            sqx_in   = ax_ff * ax_ff;
            sqy_in   = ay_ff * ay_ff;
            tsq_in   = cfg.distance_ratio * cfg.distance_ratio;
            r2_in    = cfg.radius * cfg.radius;
            state_in = ST_MULT + 4'd1;
         end
         ST_SUM: begin
            s_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};
            if (s_in == '0) begin
               n_in     = rof_pkg::N_BITS'(rof_pkg::N_SAT);
               state_in = ST_CLAMP;
            end else begin
               dvd_in   = {tsq_ff, {rof_pkg::RATIO_SHIFT{1'b0}}};
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, s_ff}) begin
               rem_in = rof_pkg::SQ_BITS'(rem_sh - {1'b0, s_ff});
               dvd_in = {dvd_ff[rof_pkg::DVD_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[rof_pkg::SQ_BITS-1:0];
               dvd_in = {dvd_ff[rof_pkg::DVD_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == rof_pkg::STEP_BITS'(rof_pkg::DVD_BITS - 1)) begin
               state_in = ST_RINIT;
            end
         end
         ST_RINIT: begin
            if (dvd_ff >= rof_pkg::DVD_BITS'(rof_pkg::SAT_LIMIT)) begin
               n_in     = rof_pkg::N_BITS'(rof_pkg::N_SAT);
               state_in = ST_CLAMP;
            end else begin
               rv_in    = dvd_ff[rof_pkg::ROOT_BITS-1:0];
               rr_in    = '0;
               rbit_in  = rof_pkg::ROOT_BITS'(1) << (rof_pkg::ROOT_BITS - 2);
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rv_ff >= root_sum) begin
               rv_in = rv_ff - root_sum;
            end
            rr_in   = rr_next;
            rbit_in = rbit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == rof_pkg::STEP_BITS'(rof_pkg::ROOT_STEPS - 1)) begin
               n_in     = rof_pkg::N_BITS'((rr_next + 1'b1) >> 1);
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            qd_in    = clamp_c[rof_pkg::PTS_BITS-1:0];
            qrem_in  = '0;
            step_in  = '0;
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            if (qrem_sh >= {1'b0, factor}) begin
               qrem_in = rof_pkg::FACTOR_BITS'(qrem_sh - {1'b0, factor});
               qd_in   = {qd_ff[rof_pkg::PTS_BITS-2:0], 1'b1};
            end else begin
               qrem_in = qrem_sh[rof_pkg::FACTOR_BITS-1:0];
               qd_in   = {qd_ff[rof_pkg::PTS_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == rof_pkg::STEP_BITS'(rof_pkg::PTS_BITS - 1)) begin
               req_in   = qd_in;
               issue_in = '0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < snap_ff) begin
               v1_in    = 1'b1;
               issue_in = issue_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_DONE;
            end
            if (v3_ff && near3_ff && dist2 <= {1'b0, r2_ff} && cnt_ff < req_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               if (inv_ff) begin
                  out_in               = '0;
                  out_in.index_invalid = 1'b1;
               end else begin
                  out_in.result_index   = rof_pkg::INDEX_BITS'(idx_ff);
                  out_in.result_x       = cx_ff;
                  out_in.result_y       = cy_ff;
                  out_in.neighbor_count = cnt_ff;
                  out_in.required_count = req_ff;
                  out_in.is_inlier      = cnt_ff >= req_ff;
                  out_in.index_invalid  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      inv_ff   <= inv_in;
      idx_ff   <= idx_in;
      snap_ff  <= snap_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      tsq_ff   <= tsq_in;
      r2_ff    <= r2_in;
      s_ff     <= s_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      rv_ff    <= rv_in;
      rr_ff    <= rr_in;
      rbit_ff  <= rbit_in;
      n_ff     <= n_in;
      qd_ff    <= qd_in;
      qrem_ff  <= qrem_in;
      req_ff   <= req_in;
      cnt_ff   <= cnt_in;
      // scan pipeline: range test, then squares
      dx_ff    <= sdx[rof_pkg::RADIUS_BITS-1:0];
      dy_ff    <= sdy[rof_pkg::RADIUS_BITS-1:0];
      near2_ff <= snear;
      px_ff    <= dx_ff * dx_ff;
      py_ff    <= dy_ff * dy_ff;
      near3_ff <= near2_ff;
   end

endmodule

// ===== src/radius_outlier_filter_2d.sv =====
// Flow: a kept load word becomes a single store write in the back part, a
// clear none; a classify word runs a 46-step divider, a 9-step root and an
// 8-step count divider, then reads one store entry a cycle through the RAM
// port into the scan pipeline.
// The back part works on one classify at a time; later jobs wait in the queue.
// Reset: registers return to their defaults, fill count and phase clear;
// ----------------------------------------------------------------------------
// radius_outlier_filter_2d
// Radius outlier removal over a store of 2D points with a CSR port.
// The point store contents stay undefined after reset and get no clearing pass.
// ----------------------------------------------------------------------------
module radius_outlier_filter_2d (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [1:0]                            req_command,
   input  logic signed [rof_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [rof_pkg::COORD_BITS-1:0] req_point_y,
   input  logic [rof_pkg::INDEX_BITS-1:0]        req_point_index,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [rof_pkg::INDEX_BITS-1:0]        rsp_result_index,
   output logic signed [rof_pkg::COORD_BITS-1:0] rsp_result_x,
   output logic signed [rof_pkg::COORD_BITS-1:0] rsp_result_y,
   output logic [rof_pkg::PTS_BITS-1:0]          rsp_neighbor_count,
   output logic [rof_pkg::PTS_BITS-1:0]          rsp_required_count,
   output logic                                  rsp_is_inlier,
   output logic                                  rsp_index_invalid,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rof_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [rof_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [rof_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   rof_pkg::cfg_type    cfg_ff;
   rof_pkg::job_type    front_job, head_job;
   rof_pkg::result_type rsp_word;
   logic                q_push, q_full, q_pop, q_empty;
   logic                ram_we;
   logic [rof_pkg::ADDR_BITS-1:0]    ram_waddr, ram_raddr;
   logic [2*rof_pkg::COORD_BITS-1:0] ram_wdata, ram_rdata;
   logic                csr_wr;
   logic [2:0]          csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[4:2];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius         <= 16'd1024;
         cfg_ff.distance_ratio <= 12'd400;
         cfg_ff.need_lo        <= 8'd4;
         cfg_ff.need_hi        <= 8'd70;
         cfg_ff.thin_factor    <= 4'd4;
         cfg_ff.pose_x         <= '0;
         cfg_ff.pose_y         <= '0;
      end else if (csr_wr) begin
         unique case (csr_reg)
            rof_pkg::REG_SEARCH_RADIUS:  cfg_ff.radius         <= csr_pwdata[15:0];
            rof_pkg::REG_DISTANCE_RATIO: cfg_ff.distance_ratio <= csr_pwdata[11:0];
            rof_pkg::REG_MIN_POINTS:     cfg_ff.need_lo        <= csr_pwdata[7:0];
            rof_pkg::REG_MAX_POINTS:     cfg_ff.need_hi        <= csr_pwdata[7:0];
            rof_pkg::REG_DOWNSAMPLE:     cfg_ff.thin_factor    <= csr_pwdata[3:0];
            rof_pkg::REG_POSE_X:         cfg_ff.pose_x         <= csr_pwdata[23:0];
            rof_pkg::REG_POSE_Y:         cfg_ff.pose_y         <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_reg)
         rof_pkg::REG_SEARCH_RADIUS:  csr_prdata = 32'(cfg_ff.radius);
         rof_pkg::REG_DISTANCE_RATIO: csr_prdata = 32'(cfg_ff.distance_ratio);
         rof_pkg::REG_MIN_POINTS:     csr_prdata = 32'(cfg_ff.need_lo);
         rof_pkg::REG_MAX_POINTS:     csr_prdata = 32'(cfg_ff.need_hi);
         rof_pkg::REG_DOWNSAMPLE:     csr_prdata = 32'(cfg_ff.thin_factor);
         rof_pkg::REG_POSE_X:         csr_prdata = {8'd0, cfg_ff.pose_x};
         rof_pkg::REG_POSE_Y:         csr_prdata = {8'd0, cfg_ff.pose_y};
         default:                     csr_prdata = '0;
      endcase
   end

   rof_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_index (req_point_index),
      .q_push          (q_push),
      .q_job           (front_job),
      .q_full          (q_full)
   );

   rof_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   rof_ram #(
      .WIDTH (2 * rof_pkg::COORD_BITS),
      .DEPTH (rof_pkg::MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rof_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   // result word fields
   assign rsp_result_index   = rsp_word.result_index;
   assign rsp_result_x       = rsp_word.result_x;
   assign rsp_result_y       = rsp_word.result_y;
   assign rsp_neighbor_count = rsp_word.neighbor_count;
   assign rsp_required_count = rsp_word.required_count;
   assign rsp_is_inlier      = rsp_word.is_inlier;
   assign rsp_index_invalid  = rsp_word.index_invalid;

endmodule

// ===== src/rof_checker.sv =====
// ----------------------------------------------------------------------------
// rof_checker
// Port-level checks on result words and the CSR port.
// ----------------------------------------------------------------------------
module rof_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [9:0] rsp_result_index,
   input logic [7:0] rsp_neighbor_count,
   input logic [7:0] rsp_required_count,
   input logic       rsp_is_inlier,
   input logic       rsp_index_invalid,
   input logic       csr_pready
);

   // a waiting word holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_index)))
      else $error("result word changed while waiting");

   // an invalid index gives an all-zero word
   a_invalid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_index_invalid) |-> (rsp_result_index == 10'd0 &&
       rsp_neighbor_count == 8'd0 && rsp_required_count == 8'd0 && !rsp_is_inlier))
      else $error("invalid word carries data");

   // inlier flag agrees with the capped count
   a_inlier: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_index_invalid) |->
      (rsp_neighbor_count <= rsp_required_count &&
       rsp_is_inlier == (rsp_neighbor_count == rsp_required_count)))
      else $error("inlier flag or count cap wrong");

   // no wait states on the CSR port
   a_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr port stalled");

endmodule

bind radius_outlier_filter_2d rof_checker u_rof_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_result_index   (rsp_result_index),
   .rsp_neighbor_count (rsp_neighbor_count),
   .rsp_required_count (rsp_required_count),
   .rsp_is_inlier      (rsp_is_inlier),
   .rsp_index_invalid  (rsp_index_invalid),
   .csr_pready         (csr_pready)
);
